@@ src/utf8d_pkg.sv @@
// Shared types, constants and lookup functions for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam logic [31:0] SUBST_CHAR = 32'd63;   // '?'
  localparam logic [7:0]  LEAD_MIN   = 8'hC0;

  typedef struct packed {
    logic [31:0] code_point;
    logic        malformed;
    logic        last;
  } result_t;

  // Results produced by one accepted byte: count 0..2, in order r0 then r1.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [2:0] lead_count(input logic [7:0] b);
    logic [2:0] cnt;
    if (b >= 8'hFC) cnt = 3'd5;
    else if (b >= 8'hF8) cnt = 3'd4;
    else if (b >= 8'hF0) cnt = 3'd3;
    else if (b >= 8'hE0) cnt = 3'd2;
    else cnt = 3'd1;
    return cnt;
  endfunction

  function automatic logic [31:0] seq_offset(input logic [2:0] len);
    logic [31:0] off;
    case (len)
      3'd1:    off = 32'h0000_3080;
      3'd2:    off = 32'h000E_2080;
      3'd3:    off = 32'h03C8_2080;
      3'd4:    off = 32'hFA08_2080;
      3'd5:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

@@ src/utf8d_byte_if.sv @@
// Byte input channel: valid/ready handshake carrying one raw byte.
// No dependencies.
`default_nettype none

interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ src/utf8d_cp_if.sv @@
// Code point output channel: valid/ready handshake carrying one decoded result.
// No dependencies.
`default_nettype none

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic        malformed;
  logic        last;

  modport source (output valid, output code_point, output malformed, output last,
                  input ready);
  modport sink   (input valid, input code_point, input malformed, input last,
                  output ready);
endinterface

`default_nettype wire

@@ src/utf8d_core.sv @@
// Decode step: sequence state registers and the per-byte result logic.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  output utf8d_pkg::push_t     push
);
  import utf8d_pkg::*;

  logic [2:0]  bytes_left, bytes_left_next;
  logic [2:0]  seq_length, seq_length_next;
  logic [31:0] accumulator, accumulator_next;
  logic [31:0] shifted;

  assign shifted = {accumulator[25:0], 6'b0} + {24'b0, in_byte};

  always_comb begin
    bytes_left_next  = bytes_left;
    seq_length_next  = seq_length;
    accumulator_next = accumulator;
    push             = '0;
    if (accept) begin
      if (bytes_left != 3'd0) begin
        if (!in_byte[7]) begin
          // sequence cut short: substitute, then the ASCII byte itself
          bytes_left_next  = 3'd0;
          seq_length_next  = 3'd0;
          accumulator_next = '0;
          push.n           = 2'd2;
          push.r0          = '{code_point: SUBST_CHAR, malformed: 1'b1, last: 1'b0};
          push.r1          = '{code_point: {24'b0, in_byte}, malformed: 1'b0, last: 1'b1};
        end else begin
          accumulator_next = shifted;
          bytes_left_next  = bytes_left - 3'd1;
          if (bytes_left == 3'd1) begin
            seq_length_next  = 3'd0;
            accumulator_next = '0;
            push.n           = 2'd1;
            push.r0          = '{code_point: shifted - seq_offset(seq_length),
                                 malformed: 1'b0, last: 1'b1};
          end
        end
      end else if (in_byte < LEAD_MIN) begin
        push.n  = 2'd1;
        push.r0 = '{code_point: {24'b0, in_byte}, malformed: 1'b0, last: 1'b1};
      end else begin
        seq_length_next  = lead_count(in_byte);
        bytes_left_next  = lead_count(in_byte);
        accumulator_next = {24'b0, in_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= 3'd0;
      seq_length  <= 3'd0;
      accumulator <= '0;
    end else begin
      bytes_left  <= bytes_left_next;
      seq_length  <= seq_length_next;
      accumulator <= accumulator_next;
    end
  end

endmodule

`default_nettype wire

@@ src/utf8d_fifo.sv @@
// Four-entry result queue taking up to two results per cycle, one out.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire utf8d_pkg::push_t  push,
  input  wire logic              pop,
  output utf8d_pkg::result_t     head,
  output logic                   not_empty,
  output logic                   has_room
);
  import utf8d_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + 2'd1;
  assign head       = mem[rd_ptr];
  assign not_empty  = (count != 3'd0);
  // room for a worst-case pair of results
  assign has_room   = (count <= 3'd2);
  assign count_next = count + {1'b0, push.n} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr_inc] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ src/utf8_stream_decoder.sv @@
// UTF-8 stream decoder top level: byte channel in, code point channel out.
// Depends on utf8d_pkg, utf8d_byte_if, utf8d_cp_if, utf8d_core, utf8d_fifo.
`default_nettype none

// Decodes the original six-byte UTF-8 form, one byte per request, into 32-bit
// code points. Each accepted byte is decoded in the cycle it is accepted and
// its results (none, one, or two when a sequence is cut short by an ASCII byte)
// are written into a four-entry result queue, so a new byte can be taken on
// every clock while the queue has room: sustained rate is one byte per cycle
// until the queue fills; results reach the output from the queue. The input
// is ready whenever the queue holds two or fewer results; it stalls when the
// output side is backed up or pairs of results come faster than they leave.
module utf8_stream_decoder (
  input wire logic     clk,
  input wire logic     rst,
  utf8d_byte_if.sink   byte_in,
  utf8d_cp_if.source   cp_out
);
  import utf8d_pkg::*;

  push_t   push;
  result_t head;
  logic    not_empty;
  logic    has_room;
  logic    accept;
  logic    pop;

  assign byte_in.ready = has_room;
  assign accept        = byte_in.valid && has_room;
  assign pop           = not_empty && cp_out.ready;

  utf8d_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (byte_in.in_byte),
    .push    (push)
  );

  utf8d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  assign cp_out.valid      = not_empty;
  assign cp_out.code_point = head.code_point;
  assign cp_out.malformed  = head.malformed;
  assign cp_out.last       = head.last;

endmodule

`default_nettype wire

@@ src/utf8d_checker.sv @@
// Port-level checks for utf8_stream_decoder, attached by bind.
// Depends on utf8_stream_decoder and utf8d_pkg.
`default_nettype none

module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] code_point,
  input wire logic        malformed,
  input wire logic        last
);
  import utf8d_pkg::*;

  // the substitute always carries '?'
  a_subst_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> code_point == SUBST_CHAR)
    else $error("malformed result without substitute value");

  // the substitute is never the final result of its byte
  a_subst_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> !last)
    else $error("malformed result marked last");

  // the byte that follows a substitute is queued together with it
  a_subst_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && malformed |=> out_valid && !malformed && last)
    else $error("substitute not followed by its companion result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
      && $stable(malformed) && $stable(last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (cp_out.valid),
  .out_ready  (cp_out.ready),
  .code_point (cp_out.code_point),
  .malformed  (cp_out.malformed),
  .last       (cp_out.last)
);

`default_nettype wire

@@ dv/utf8_stream_decoder_test.sv @@
// Self-checking testbench for utf8_stream_decoder: directed and random byte streams.
// Depends on utf8d_pkg, utf8d_byte_if, utf8d_cp_if and the decoder RTL.

module utf8_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no request moving
  localparam int unsigned DRAIN_CYCLES = 4;

  logic clk = 1'b0;
  logic rst;

  utf8d_byte_if byte_in ();
  utf8d_cp_if cp_out ();

  utf8_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .cp_out(cp_out)
  );

  always #4 clk = ~clk;

  // Decoder state as seen by the predictor
  logic [2:0] cont_left;
  logic [2:0] seq_len;
  logic [31:0] acc_value;
  result_t expected_cps[$];

  int unsigned fail_count;
  int unsigned idle_cycles;
  bit src_jitter;
  bit sink_jitter;
  int unsigned sink_hold_req;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Continuations announced by a lead byte: first zero bit below bit 6.
  function automatic logic [2:0] trail_count(input logic [7:0] b);
    if (!b[5]) return 3'd1;
    if (!b[4]) return 3'd2;
    if (!b[3]) return 3'd3;
    if (!b[2]) return 3'd4;
    return 3'd5;
  endfunction

  // Sum of the lead and continuation tag bits left in the accumulator.
  function automatic logic [31:0] tag_bias(input logic [2:0] len);
    case (len)
      3'd1: return 32'h0000_3080;
      3'd2: return 32'h000E_2080;
      3'd3: return 32'h03C8_2080;
      3'd4: return 32'hFA08_2080;
      3'd5: return 32'h8208_2080;
      default: return 32'h0;
    endcase
  endfunction

  function automatic void queue_cp(input logic [31:0] cp, input logic bad, input logic fin);
    result_t r;
    r.code_point = cp;
    r.malformed = bad;
    r.last = fin;
    expected_cps.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (cont_left != 3'd0) begin
      if (!b[7]) begin
        // ASCII cuts the open sequence short
        cont_left = 3'd0;
        seq_len = 3'd0;
        acc_value = 32'h0;
        queue_cp(SUBST_CHAR, 1'b1, 1'b0);
        queue_cp({24'h0, b}, 1'b0, 1'b1);
      end else begin
        acc_value = (acc_value << 6) + {24'h0, b};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          queue_cp(acc_value - tag_bias(seq_len), 1'b0, 1'b1);
          seq_len = 3'd0;
          acc_value = 32'h0;
        end
      end
    end else if (b < LEAD_MIN) begin
      queue_cp({24'h0, b}, 1'b0, 1'b1);
    end else begin
      seq_len = trail_count(b);
      cont_left = seq_len;
      acc_value = {24'h0, b};
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_jitter ? pick_gap() : 0;
    if (gap != 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.in_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    decode_byte(b);
  endtask

  // Stop offering, let every expected result arrive, then wait out DRAIN_CYCLES quiet cycles.
  task automatic settle();
    byte_in.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_of(input int unsigned len);
    case (len)
      1: return 8'($urandom_range(8'hC0, 8'hDF));
      2: return 8'($urandom_range(8'hE0, 8'hEF));
      3: return 8'($urandom_range(8'hF0, 8'hF7));
      4: return 8'($urandom_range(8'hF8, 8'hFB));
      default: return 8'($urandom_range(8'hFC, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] cont_of();
    // mostly proper continuation bytes, sometimes a lead byte standing in
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(8'hC0, 8'hFF));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Mostly well-formed sequences with random content, some cut short, some noise.
  task automatic send_mixed_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_byte(8'($urandom_range(0, 8'h7F)));
        sent++;
      end else if (kind < 75) begin
        len = $urandom_range(1, 5);
        send_byte(lead_of(len));
        repeat (len) send_byte(cont_of());
        sent += len + 1;
      end else if (kind < 87) begin
        len = $urandom_range(1, 5);
        cut = $urandom_range(0, len - 1);
        send_byte(lead_of(len));
        repeat (cut) send_byte(cont_of());
        send_byte(8'($urandom_range(0, 8'h7F)));
        sent += cut + 2;
      end else begin
        send_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);  // stray continuations come out as themselves
    send_byte(8'hBF);
    settle();
  endtask

  task automatic test_sequence_lengths();
    send_byte(8'hC0);
    send_byte(8'h80);
    // lead bytes inside a sequence count as continuations
    send_byte(8'hEF);
    send_byte(8'hC3);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    // sequence left open across an idle input, finished later
    send_byte(8'hF8);
    send_byte(8'h80);
    settle();
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'hFF);
    repeat (5) send_byte(8'hBF);
    settle();
  endtask

  task automatic test_cut_short();
    send_byte(8'hE2);
    send_byte(8'h41);
    send_byte(8'hFC);
    send_byte(8'h80);
    send_byte(8'h00);
    settle();
  endtask

  task automatic test_idle_mix();
    src_jitter = 1'b1;
    sink_jitter = 1'b1;
    send_mixed_stream(1100);
    settle();
  endtask

  task automatic test_full_rate();
    src_jitter = 1'b0;
    sink_jitter = 1'b0;
    send_mixed_stream(400);
    settle();
  endtask

  // Receiver holds off long enough for the result queue to fill and stall input.
  task automatic test_backpressure();
    src_jitter = 1'b0;
    sink_jitter = 1'b1;
    sink_hold_req = 200;
    send_mixed_stream(150);
    settle();
    src_jitter = 1'b1;
    send_mixed_stream(300);
    settle();
  endtask

  // Result receiver
  initial begin : result_sink
    int unsigned stall;
    cp_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req != 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        stall = sink_jitter ? pick_gap() : 0;
      end
      if (stall != 0) begin
        cp_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cp_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && cp_out.valid && cp_out.ready) begin
      if (expected_cps.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%h malformed=%b last=%b",
                                  cp_out.code_point, cp_out.malformed, cp_out.last));
      end else begin
        want = expected_cps.pop_front();
        if (cp_out.code_point !== want.code_point)
          report_mismatch($sformatf("code_point %h, want %h",
                                    cp_out.code_point, want.code_point));
        if (cp_out.malformed !== want.malformed)
          report_mismatch($sformatf("malformed %b, want %b",
                                    cp_out.malformed, want.malformed));
        if (cp_out.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", cp_out.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_in.valid && byte_in.ready) || (cp_out.valid && cp_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("utf8_stream_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    src_jitter = 1'b0;
    sink_jitter = 1'b0;
    sink_hold_req = 0;
    cont_left = 3'd0;
    seq_len = 3'd0;
    acc_value = 32'h0;
    rst <= 1'b1;
    byte_in.valid <= 1'b0;
    byte_in.in_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_plain_bytes();
    test_sequence_lengths();
    test_cut_short();
    test_idle_mix();
    test_full_rate();
    test_backpressure();

    if (fail_count == 0) begin
      $display("utf8_stream_decoder regression: pass");
    end else begin
      $display("utf8_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/utf8d_pkg.sv
src/utf8d_byte_if.sv
src/utf8d_cp_if.sv
src/utf8d_core.sv
src/utf8d_fifo.sv
src/utf8_stream_decoder.sv
src/utf8d_checker.sv
dv/utf8_stream_decoder_test.sv
